// ===== design/ctp_pkg.sv =====
`timescale 1ns / 1ps
package ctp_pkg;
    localparam int DATA_W      = 32;
    localparam int FRAC_BITS_D = 16;
    localparam int NUM_REGS    = 8;
    localparam int IDX_W       = 3;
    localparam logic [IDX_W-1:0] REG_X_START = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_SPAN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_T_START = 3'd2;
    localparam logic [IDX_W-1:0] REG_T_SPAN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_Y_COEF0 = 3'd4;
    localparam logic [IDX_W-1:0] REG_Y_COEF1 = 3'd5;
    localparam logic [IDX_W-1:0] REG_Y_COEF2 = 3'd6;
    localparam logic [IDX_W-1:0] REG_Y_COEF3 = 3'd7;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        if (v > 72'sd2147483647) return 32'sh7fffffff;
        if (v < -72'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

// ===== design/ctp_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with input and
// output registers. Quotient truncates toward zero and saturates to 32 bits.
module ctp_div #(
    parameter int FRAC_BITS = ctp_pkg::FRAC_BITS_D
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [32:0]  i_num,
    input  logic signed [31:0]  i_den,
    output logic signed [31:0]  o_quo
);
    import ctp_pkg::*;
    localparam int NW = 33 + FRAC_BITS;
    localparam int QW = NW;

    logic [NW-1:0] r_n   [0:QW];
    logic [31:0]   r_d   [0:QW];
    logic [NW:0]   r_rem [0:QW];
    logic [QW-1:0] r_q   [0:QW];
    logic          r_neg [0:QW];
    logic signed [31:0] r_out;

    logic signed [NW-1:0] n_scaled;
    logic signed [32:0]   n_den;
    always_comb begin
        n_scaled = NW'(i_num) <<< FRAC_BITS;
        n_den    = 33'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= n_scaled[NW-1] ? NW'(-n_scaled) : n_scaled;
            r_d[0]   <= n_den[32] ? 32'(-n_den) : 32'(n_den);
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_neg[0] <= n_scaled[NW-1] ^ n_den[32];
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_st
        logic [NW:0] n_tr;
        logic        n_ge;
        always_comb begin
            n_tr = {r_rem[s][NW-1:0], r_n[s][NW-1-s]};
            n_ge = n_tr >= (NW+1)'(r_d[s]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[s+1]   <= r_n[s];
                r_d[s+1]   <= r_d[s];
                r_neg[s+1] <= r_neg[s];
                r_rem[s+1] <= n_ge ? n_tr - (NW+1)'(r_d[s]) : n_tr;
                r_q[s+1]   <= {r_q[s][QW-2:0], n_ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= sat32(r_neg[QW] ? -72'(r_q[QW]) : 72'(r_q[QW]));
        end
    end
    assign o_quo = r_out;
endmodule

// ===== design/ctp_qmul.sv =====
`timescale 1ns / 1ps
// Registered Q-format multiply: product registered, then floor shift and
// saturation registered.
module ctp_qmul #(
    parameter int FRAC_BITS = ctp_pkg::FRAC_BITS_D
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_p
);
    import ctp_pkg::*;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_p;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
            r_p    <= sat32(72'(r_prod >>> FRAC_BITS));
        end
    end
    assign o_p = r_p;
endmodule

// ===== design/cubic_trajectory_point.sv =====
`timescale 1ns / 1ps
// Cubic trajectory set-point generator.
// Program the eight registers (x_start, x_span, t_start, t_span, y_coef0..3)
// through the configuration channel (i_cfg_valid / o_cfg_ready, index and
// data) while no item is in flight; o_cfg_ready is always high.
// A command beat is taken when i_start is high; o_busy is always low, so a
// new item may enter on every clock cycle.
// Each result appears on o_x_set, o_y_set and o_span_error for one cycle,
// marked by o_done (data in Q16.16 for the default FRAC_BITS of 16). The two
// pipelined dividers run side by side up to their output register, then the
// product chain follows (squares, cubes, blend, final products) and the
// saturated sums are registered last.
// Throughput is one item per cycle; the divider stages dominate the latency.
// The receiver cannot stall, so the pipeline advances every cycle.
// A synchronous reset clears the configuration registers to zero and empties
// the pipeline.
module cubic_trajectory_point #(
    parameter int FRAC_BITS = ctp_pkg::FRAC_BITS_D
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic signed [31:0]          i_x_now,
    input  logic signed [31:0]          i_t_now,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ctp_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    output logic                        o_done,
    output logic signed [31:0]          o_x_set,
    output logic signed [31:0]          o_y_set,
    output logic                        o_span_error
);
    import ctp_pkg::*;
    localparam int DL = FRAC_BITS + 35;
    localparam int LAT = DL + 7;

    logic signed [31:0] r_x_start, r_x_span, r_t_start, r_t_span;
    logic signed [31:0] r_c0, r_c1, r_c2, r_c3;
    logic [LAT-1:0] r_vld;
    logic en;
    assign en = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_start <= '0; r_x_span <= '0; r_t_start <= '0; r_t_span <= '0;
            r_c0 <= '0; r_c1 <= '0; r_c2 <= '0; r_c3 <= '0;
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start};
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_X_START: r_x_start <= i_cfg_data;
                    REG_X_SPAN:  r_x_span  <= i_cfg_data;
                    REG_T_START: r_t_start <= i_cfg_data;
                    REG_T_SPAN:  r_t_span  <= i_cfg_data;
                    REG_Y_COEF0: r_c0 <= i_cfg_data;
                    REG_Y_COEF1: r_c1 <= i_cfg_data;
                    REG_Y_COEF2: r_c2 <= i_cfg_data;
                    REG_Y_COEF3: r_c3 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Tau and d are divided in parallel.
    logic signed [31:0] n_tau, n_d;
    logic signed [31:0] tau_q, d_q;
    ctp_div #(.FRAC_BITS(FRAC_BITS)) u_div_t (.i_clk, .i_en(en),
        .i_num(33'(i_t_now) - 33'(r_t_start)), .i_den(r_t_span), .o_quo(tau_q));
    ctp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (.i_clk, .i_en(en),
        .i_num(33'(i_x_now) - 33'(r_x_start)), .i_den(r_x_span), .o_quo(d_q));
    // A zero span yields a saturated quotient; only tau is forced to zero here.
    assign n_tau = (r_t_span == 0) ? '0 : tau_q;
    assign n_d   = d_q;

    // Stage A: squares.
    logic signed [31:0] tau2, d2;
    ctp_qmul #(.FRAC_BITS(FRAC_BITS)) u_m0 (.i_clk, .i_en(en), .i_a(n_tau), .i_b(n_tau), .o_p(tau2));
    ctp_qmul #(.FRAC_BITS(FRAC_BITS)) u_m1 (.i_clk, .i_en(en), .i_a(n_d), .i_b(n_d), .o_p(d2));
    logic signed [31:0] r_tau_a [0:1], r_d_a [0:1];
    always_ff @(posedge i_clk) begin
        r_tau_a[0] <= n_tau; r_tau_a[1] <= r_tau_a[0];
        r_d_a[0] <= n_d;     r_d_a[1] <= r_d_a[0];
    end
    // Stage B: cubes and d products.
    logic signed [31:0] tau3, d3, p1, p2;
    ctp_qmul #(.FRAC_BITS(FRAC_BITS)) u_m2 (.i_clk, .i_en(en), .i_a(tau2), .i_b(r_tau_a[1]), .o_p(tau3));
    ctp_qmul #(.FRAC_BITS(FRAC_BITS)) u_m3 (.i_clk, .i_en(en), .i_a(d2), .i_b(r_d_a[1]), .o_p(d3));
    ctp_qmul #(.FRAC_BITS(FRAC_BITS)) u_m4 (.i_clk, .i_en(en), .i_a(r_c1), .i_b(r_d_a[1]), .o_p(p1));
    ctp_qmul #(.FRAC_BITS(FRAC_BITS)) u_m5 (.i_clk, .i_en(en), .i_a(r_c2), .i_b(d2), .o_p(p2));
    logic signed [31:0] r_tau2_b [0:1];
    always_ff @(posedge i_clk) begin
        r_tau2_b[0] <= tau2; r_tau2_b[1] <= r_tau2_b[0];
    end
    // Stage C: blend h, and c3*d3 (h registered, then multiplied).
    logic signed [31:0] r_h, hx, p3, r_p1c, r_p2c, r_p1d, r_p2d, r_p1e, r_p2e;
    always_ff @(posedge i_clk) begin
        r_h <= sat32(72'(r_tau2_b[1]) * 3 - 72'(tau3) * 2);
        r_p1c <= p1; r_p2c <= p2;
    end
    ctp_qmul #(.FRAC_BITS(FRAC_BITS)) u_m6 (.i_clk, .i_en(en), .i_a(r_x_span), .i_b(r_h), .o_p(hx));
    logic signed [31:0] r_d3c;
    always_ff @(posedge i_clk) r_d3c <= d3;
    ctp_qmul #(.FRAC_BITS(FRAC_BITS)) u_m7 (.i_clk, .i_en(en), .i_a(r_c3), .i_b(r_d3c), .o_p(p3));
    always_ff @(posedge i_clk) begin
        r_p1d <= r_p1c; r_p2d <= r_p2c;
        r_p1e <= r_p1d; r_p2e <= r_p2d;
    end
    // Final sums, held in the output register.
    logic signed [31:0] r_xs, r_ys;
    logic r_err;
    logic [DL+6:0] r_zt, r_zx;
    always_ff @(posedge i_clk) begin
        r_zt <= {r_zt[DL+5:0], r_t_span == 0};
        r_zx <= {r_zx[DL+5:0], r_x_span == 0};
        if (r_zx[DL+6]) begin
            r_xs <= r_x_start;
            r_ys <= sat32(72'(r_c0) + 72'(r_c1) + 72'(r_c2) + 72'(r_c3));
        end else begin
            r_xs <= sat32(72'(r_x_start) + 72'(hx));
            r_ys <= sat32(72'(r_c0) + 72'(r_p1e) + 72'(r_p2e) + 72'(p3));
        end
        r_err <= r_zt[DL+6];
    end

    // Done aligns with the result register.
    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else r_done <= r_vld[LAT-1];
    end

    assign o_busy = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_done = r_done;
    assign o_x_set = r_xs;
    assign o_y_set = r_ys;
    assign o_span_error = r_err;

    a_busy: assert property (@(posedge i_clk) !o_busy) else $error("busy");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done == $past(r_vld[LAT-1])) else $error("done misaligned");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_done) else $error("reset");
endmodule
